### design/corner_hugging_diagonal_detour_macros.svh
// assertion macros for the corner hugging diagonal detour block
// no dependencies; included by the modules that carry assertions
`ifndef CORNER_HUGGING_DIAGONAL_DETOUR_MACROS_SVH
`define CORNER_HUGGING_DIAGONAL_DETOUR_MACROS_SVH
`ifndef ASSERT_OFF
// checked property, switched off while reset is high
`define CHDD_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, also through reset
`define CHDD_ASSERT_ALW(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHDD_ASSERT_RST(lbl, clk, rst, prop, msg)
`define CHDD_ASSERT_ALW(lbl, clk, prop, msg)
`endif
`endif

### design/chdd_pkg.sv
// shared constants, types and helpers of the corner hugging diagonal detour block
// no dependencies; imported by every module of the block
package chdd_pkg;

  localparam int MAP_CELLS     = 65536;
  localparam int MAX_SEG_STEPS = 32;
  localparam int FRAC_BITS     = 4;

  localparam int PT_W       = 13;
  localparam int OUT_W      = 14;
  localparam int IDX_W      = 16;
  localparam int COST_W     = 8;
  localparam int DIM_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam int MAP_AW = $clog2(MAP_CELLS);
  localparam int ONE_I  = 1 << FRAC_BITS;
  localparam int HALF_I = 1 << (FRAC_BITS - 1);
  // walk coordinates cover a point plus a full clamped walk
  localparam int WALK_W = $clog2((1 << (PT_W - 1)) + MAX_SEG_STEPS * ONE_I) + 1;
  localparam int DIFF_W = PT_W + 1;
  localparam int RND_W  = DIFF_W + 1;
  localparam int STEP_W = $clog2(MAX_SEG_STEPS + 1);
  localparam int PROD_W = WALK_W + DIM_W;

  localparam logic [PROD_W-1:0]        MAP_CELLS_P = PROD_W'(MAP_CELLS);
  localparam logic signed [WALK_W-1:0] ONE         = WALK_W'(ONE_I);

  localparam logic OP_MAP_WRITE = 1'b0;
  localparam logic OP_POINT     = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_WIDTH       = 3'd0,
    CFG_MAP_HEIGHT      = 3'd1,
    CFG_UNKNOWN_OK      = 3'd2,
    CFG_UNKNOWN_LEVEL   = 3'd3,
    CFG_INSCRIBED_LEVEL = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [DIM_W-1:0]  map_width;
    logic [DIM_W-1:0]  map_height;
    logic              unknown_ok;
    logic [COST_W-1:0] unknown_level;
    logic [COST_W-1:0] inscribed_level;
  } chdd_cfg_t;

  typedef struct packed {
    logic              oob;
    logic [MAP_AW-1:0] addr;
  } chdd_probe_t;

  function automatic logic cost_blocked(input logic [COST_W-1:0] c, input chdd_cfg_t cfg);
    logic blk;
    if (c == cfg.unknown_level) blk = !cfg.unknown_ok;
    else blk = (c >= cfg.inscribed_level);
    return blk;
  endfunction

endpackage

### design/chdd_map_ram.sv
// cost map storage: one write port, two registered read ports
// depends on chdd_pkg
module chdd_map_ram import chdd_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [MAP_AW-1:0] waddr,
  input  logic [COST_W-1:0] wdata,
  input  logic              re,
  input  logic [MAP_AW-1:0] raddr_a,
  input  logic [MAP_AW-1:0] raddr_b,
  output logic [COST_W-1:0] rdata_a,
  output logic [COST_W-1:0] rdata_b
);

  logic [COST_W-1:0] mem [MAP_CELLS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### design/chdd_cell_probe.sv
// turns a fixed point coordinate pair into a map address and an outside flag
// depends on chdd_pkg
module chdd_cell_probe import chdd_pkg::*; (
  input  logic signed [WALK_W-1:0] fx,
  input  logic signed [WALK_W-1:0] fy,
  input  chdd_cfg_t                cfg,
  output chdd_probe_t              probe
);

  logic              neg_x;
  logic              neg_y;
  logic [WALK_W-1:0] ix;
  logic [WALK_W-1:0] iy;
  logic              outside;
  logic [PROD_W-1:0] addr_full;

  // truncation toward zero: anything above minus one cell lands in cell 0
  assign neg_x = (fx <= -ONE);
  assign neg_y = (fy <= -ONE);
  assign ix = fx[WALK_W-1] ? '0 : $unsigned(fx >>> FRAC_BITS);
  assign iy = fy[WALK_W-1] ? '0 : $unsigned(fy >>> FRAC_BITS);

  assign outside = neg_x || neg_y ||
                   (ix >= WALK_W'(cfg.map_width)) || (iy >= WALK_W'(cfg.map_height));
  assign addr_full = PROD_W'(iy) * PROD_W'(cfg.map_width) + PROD_W'(ix);

  assign probe.oob  = outside || (addr_full >= MAP_CELLS_P);
  assign probe.addr = addr_full[MAP_AW-1:0];

endmodule

### design/chdd_walk.sv
// point sequencer: rounding, diagonal walk with map lookups, output register
// depends on chdd_pkg, chdd_cell_probe and the block macro header
`include "corner_hugging_diagonal_detour_macros.svh"

module chdd_walk import chdd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  chdd_cfg_t               cfg,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    opcode,
  input  logic signed [PT_W-1:0]  point_x,
  input  logic signed [PT_W-1:0]  point_y,
  input  logic                    path_start,
  output logic                    ram_re,
  output logic [MAP_AW-1:0]       ram_raddr_a,
  output logic [MAP_AW-1:0]       ram_raddr_b,
  input  logic [COST_W-1:0]       ram_rdata_a,
  input  logic [COST_W-1:0]       ram_rdata_b,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_x,
  output logic signed [OUT_W-1:0] out_y,
  output logic                    last_of_run,
  output logic                    steps_saturated
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PREP = 7'b0000010,
    S_PASS = 7'b0000100,
    S_ADDR = 7'b0001000,
    S_LOOK = 7'b0010000,
    S_SIDE = 7'b0100000,
    S_DIAG = 7'b1000000
  } state_t;

  state_t                   state;
  logic                     have_prev;
  logic signed [PT_W-1:0]   prev_x;
  logic signed [PT_W-1:0]   prev_y;
  logic signed [PT_W-1:0]   tx;
  logic signed [PT_W-1:0]   ty;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [WALK_W-1:0] cx;
  logic signed [WALK_W-1:0] cy;
  logic signed [WALK_W-1:0] nx;
  logic signed [WALK_W-1:0] ny;
  logic                     sx_neg;
  logic                     sy_neg;
  logic                     sat;
  logic [STEP_W-1:0]        left;
  logic                     h_oob;
  logic                     v_oob;
  logic                     side_h;

  logic [RND_W-1:0]  mag_x;
  logic [RND_W-1:0]  mag_y;
  logic [RND_W-1:0]  rx;
  logic [RND_W-1:0]  ry;
  logic [RND_W-1:0]  steps_max;
  logic              over;
  logic [STEP_W-1:0] steps_clamped;
  logic              zero_seg;
  chdd_probe_t       probe_h;
  chdd_probe_t       probe_v;
  logic              h_free;
  logic              v_free;
  logic              in_accept;
  logic              out_free;
  logic              load;
  logic              load_last;

  // round the differences to whole cells, half away from zero
  assign mag_x = dx[DIFF_W-1] ? RND_W'($unsigned(-dx)) : RND_W'($unsigned(dx));
  assign mag_y = dy[DIFF_W-1] ? RND_W'($unsigned(-dy)) : RND_W'($unsigned(dy));
  assign rx = (mag_x + RND_W'(HALF_I)) >> FRAC_BITS;
  assign ry = (mag_y + RND_W'(HALF_I)) >> FRAC_BITS;
  assign steps_max = (rx > ry) ? rx : ry;
  assign over = (steps_max > RND_W'(MAX_SEG_STEPS));
  assign steps_clamped = over ? STEP_W'(MAX_SEG_STEPS) : steps_max[STEP_W-1:0];
  assign zero_seg = (rx == '0) || (ry == '0);

  assign nx = cx + (sx_neg ? -ONE : ONE);
  assign ny = cy + (sy_neg ? -ONE : ONE);

  chdd_cell_probe u_probe_h (.fx(nx), .fy(cy), .cfg(cfg), .probe(probe_h));
  chdd_cell_probe u_probe_v (.fx(cx), .fy(ny), .cfg(cfg), .probe(probe_v));

  assign ram_re      = (state == S_ADDR);
  assign ram_raddr_a = probe_h.addr;
  assign ram_raddr_b = probe_v.addr;

  assign h_free = !h_oob && !cost_blocked(ram_rdata_a, cfg);
  assign v_free = !v_oob && !cost_blocked(ram_rdata_b, cfg);

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && (state == S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign load      = out_free && ((state == S_PASS) || (state == S_SIDE) || (state == S_DIAG));
  assign load_last = load && ((state == S_PASS) ||
                              ((state == S_DIAG) && (left == STEP_W'(1))));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      have_prev <= 1'b0;
      prev_x    <= '0;
      prev_y    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept && (opcode == OP_POINT)) begin
            tx        <= point_x;
            ty        <= point_y;
            dx        <= DIFF_W'(point_x) - DIFF_W'(prev_x);
            dy        <= DIFF_W'(point_y) - DIFF_W'(prev_y);
            cx        <= WALK_W'(prev_x);
            cy        <= WALK_W'(prev_y);
            prev_x    <= point_x;
            prev_y    <= point_y;
            have_prev <= 1'b1;
            state     <= (path_start || !have_prev) ? S_PASS : S_PREP;
          end
        end
        S_PREP: begin
          sx_neg <= dx[DIFF_W-1];
          sy_neg <= dy[DIFF_W-1];
          sat    <= over;
          left   <= steps_clamped;
          state  <= zero_seg ? S_PASS : S_ADDR;
        end
        S_PASS: begin
          if (out_free) state <= S_IDLE;
        end
        S_ADDR: begin
          h_oob <= probe_h.oob;
          v_oob <= probe_v.oob;
          state <= S_LOOK;
        end
        S_LOOK: begin
          side_h <= h_free;
          state  <= (h_free != v_free) ? S_SIDE : S_DIAG;
        end
        S_SIDE: begin
          if (out_free) state <= S_DIAG;
        end
        S_DIAG: begin
          if (out_free) begin
            cx    <= nx;
            cy    <= ny;
            left  <= left - STEP_W'(1);
            state <= (left == STEP_W'(1)) ? S_IDLE : S_ADDR;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last_of_run <= load_last;
      priority if (state == S_PASS) begin
        out_x           <= OUT_W'(tx);
        out_y           <= OUT_W'(ty);
        steps_saturated <= 1'b0;
      end else if (state == S_SIDE) begin
        out_x           <= side_h ? nx[OUT_W-1:0] : cx[OUT_W-1:0];
        out_y           <= side_h ? cy[OUT_W-1:0] : ny[OUT_W-1:0];
        steps_saturated <= sat;
      end else begin
        out_x           <= nx[OUT_W-1:0];
        out_y           <= ny[OUT_W-1:0];
        steps_saturated <= sat;
      end
    end
  end

  `CHDD_ASSERT_ALW(a_reset_idle, clk, rst |=> !out_valid && state == S_IDLE, "reset left work")
  `CHDD_ASSERT_RST(a_start_passes, clk, rst, in_accept && opcode == OP_POINT && path_start |=> state == S_PASS, "path start not passed through")
  `CHDD_ASSERT_RST(a_diag_has_steps, clk, rst, state == S_DIAG |-> left != '0, "diagonal beat with no step left")
  `CHDD_ASSERT_RST(a_last_ends_run, clk, rst, load_last |=> state == S_IDLE && out_valid && last_of_run, "final beat did not end the run")

endmodule

### design/corner_hugging_diagonal_detour.sv
// top level of the corner hugging diagonal detour block: config registers, map, walker
// depends on chdd_pkg, chdd_map_ram and chdd_walk
//
// usage
//   input channel (in_valid / in_stall) carries one beat per map write or path point.
//   opcode OP_MAP_WRITE stores cell_cost at cell_index and yields no beat.
//   opcode OP_POINT presents a path point; a first point, or a segment whose rounded
//   step is zero on an axis, comes back unchanged as one beat with last_of_run set.
//   otherwise the block walks up to MAX_SEG_STEPS diagonal steps from the previous
//   point, emitting a detour beat before a diagonal beat where exactly one
//   orthogonal neighbor is blocked; the final beat of a point carries last_of_run.
// sequence
//   a pass-through beat is loaded from S_PASS, reached straight from acceptance for
//   a first point and through S_PREP for a straight move.
//   each walk step passes address, map read and diagonal beat states, with a detour
//   beat state before the diagonal beat where needed; out_stall can hold beat states.
//   the input stalls until the final beat loads. one point is in work at a time.
//   a finished beat waits in the output register while the next item is accepted.
// stall and reset
//   out_stall holds the output register and pauses the walk; nothing is dropped.
//   reset restores the register defaults and forgets the previous point; the map
//   contents stay undefined until written, and no clearing pass runs. cfg_write takes
//   one register per cycle; the user writes only while the block is idle, unenforced.
module corner_hugging_diagonal_detour import chdd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  // configuration write port
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    opcode,
  input  logic [IDX_W-1:0]        cell_index,
  input  logic [COST_W-1:0]       cell_cost,
  input  logic signed [PT_W-1:0]  point_x,
  input  logic signed [PT_W-1:0]  point_y,
  input  logic                    path_start,
  // output channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_x,
  output logic signed [OUT_W-1:0] out_y,
  output logic                    last_of_run,
  output logic                    steps_saturated
);

  chdd_cfg_t         cfg;
  logic              map_we;
  logic [PROD_W-1:0] widx_ext;
  logic              ram_re;
  logic [MAP_AW-1:0] ram_raddr_a;
  logic [MAP_AW-1:0] ram_raddr_b;
  logic [COST_W-1:0] ram_rdata_a;
  logic [COST_W-1:0] ram_rdata_b;

  // configuration registers, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_width       <= DIM_W'(256);
      cfg.map_height      <= DIM_W'(256);
      cfg.unknown_ok      <= 1'b0;
      cfg.unknown_level   <= COST_W'(255);
      cfg.inscribed_level <= COST_W'(253);
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MAP_WIDTH:       cfg.map_width       <= cfg_data[DIM_W-1:0];
        CFG_MAP_HEIGHT:      cfg.map_height      <= cfg_data[DIM_W-1:0];
        CFG_UNKNOWN_OK:      cfg.unknown_ok      <= cfg_data[0];
        CFG_UNKNOWN_LEVEL:   cfg.unknown_level   <= cfg_data[COST_W-1:0];
        CFG_INSCRIBED_LEVEL: cfg.inscribed_level <= cfg_data[COST_W-1:0];
        default: ;
      endcase
    end
  end

  // map write beats go straight to the memory; addresses past the store are ignored
  assign widx_ext = PROD_W'(cell_index);
  assign map_we   = in_valid && !in_stall && (opcode == OP_MAP_WRITE) &&
                    (widx_ext < MAP_CELLS_P);

  chdd_map_ram u_map (
    .clk     (clk),
    .we      (map_we),
    .waddr   (widx_ext[MAP_AW-1:0]),
    .wdata   (cell_cost),
    .re      (ram_re),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  // sequencer: takes the point beats, reads neighbor costs, drives the output register
  chdd_walk u_walk (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .opcode          (opcode),
    .point_x         (point_x),
    .point_y         (point_y),
    .path_start      (path_start),
    .ram_re          (ram_re),
    .ram_raddr_a     (ram_raddr_a),
    .ram_raddr_b     (ram_raddr_b),
    .ram_rdata_a     (ram_rdata_a),
    .ram_rdata_b     (ram_rdata_b),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_x           (out_x),
    .out_y           (out_y),
    .last_of_run     (last_of_run),
    .steps_saturated (steps_saturated)
  );

endmodule

### sim/tb_corner_hugging_diagonal_detour.sv
// self-checking testbench for the corner hugging diagonal detour block
// drives map writes and path points, predicts every emitted beat; needs chdd_pkg
module tb_corner_hugging_diagonal_detour;
  import chdd_pkg::*;

  localparam int RUN_LIMIT = 500000;

  typedef struct packed {
    logic                   op;
    logic [IDX_W-1:0]       idx;
    logic [COST_W-1:0]      cost;
    logic signed [PT_W-1:0] px;
    logic signed [PT_W-1:0] py;
    logic                   start;
  } path_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic                    last;
    logic                    sat;
  } detour_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = CFG_MAP_WIDTH;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    opcode = OP_MAP_WRITE;
  logic [IDX_W-1:0]        cell_index = '0;
  logic [COST_W-1:0]       cell_cost = '0;
  logic signed [PT_W-1:0]  point_x = '0;
  logic signed [PT_W-1:0]  point_y = '0;
  logic                    path_start = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [OUT_W-1:0] out_x;
  logic signed [OUT_W-1:0] out_y;
  logic                    last_of_run;
  logic                    steps_saturated;

  corner_hugging_diagonal_detour u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .cell_index(cell_index), .cell_cost(cell_cost),
    .point_x(point_x), .point_y(point_y), .path_start(path_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y),
    .last_of_run(last_of_run), .steps_saturated(steps_saturated)
  );

  // stimulus side
  path_item_t   pending_items[$];
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           cycle_count = 0;
  int           mismatch_count = 0;

  // generator view: which cells hold a known cost, and where the path stands
  bit           cost_written [0:MAP_CELLS-1];
  int           gen_x = 0;
  int           gen_y = 0;
  bit           gen_started = 1'b0;
  int           zone_x0, zone_y0, zone_w, zone_h;

  // predictor state
  logic [COST_W-1:0] map_cost [0:MAP_CELLS-1];
  int           trail_x = 0;
  int           trail_y = 0;
  bit           trail_open = 1'b0;
  chdd_cfg_t    model_cfg = '{map_width: 9'd256, map_height: 9'd256, unknown_ok: 1'b0,
                              unknown_level: 8'd255, inscribed_level: 8'd253};
  detour_beat_t detour_beats[$];

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("tb_corner_hugging_diagonal_detour: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // half away from zero, to whole cells
  function automatic int round_cells(input int v);
    int mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + HALF_I) >>> FRAC_BITS;
    return (v < 0) ? -mag : mag;
  endfunction

  // cell index truncates toward zero, so -0.5 lands in cell 0
  function automatic bit cell_blocked(input int fx, input int fy);
    int ix, iy, w, h, addr;
    logic [COST_W-1:0] c;
    ix = fx / ONE_I;
    iy = fy / ONE_I;
    w = model_cfg.map_width;
    h = model_cfg.map_height;
    if (ix < 0 || iy < 0 || ix >= w || iy >= h) return 1'b1;
    addr = iy * w + ix;
    if (addr >= MAP_CELLS) return 1'b1;
    c = map_cost[addr];
    if (c == model_cfg.unknown_level) return !model_cfg.unknown_ok;
    return c >= model_cfg.inscribed_level;
  endfunction

  task automatic expect_beat(input int x, input int y, input bit last, input bit sat);
    detour_beat_t b;
    b.x = OUT_W'(x);
    b.y = OUT_W'(y);
    b.last = last;
    b.sat = sat;
    detour_beats = {detour_beats, b};
  endtask

  // one accepted input beat -> zero or more expected output beats
  task automatic detour_item(input logic op, input logic [IDX_W-1:0] idx,
                             input logic [COST_W-1:0] cost,
                             input logic signed [PT_W-1:0] px,
                             input logic signed [PT_W-1:0] py, input logic start);
    int x1, y1, rdx, rdy, ax, ay, steps, sx, sy, cx, cy;
    bit sat, hf, vf;
    if (op == OP_MAP_WRITE) begin
      map_cost[idx] = cost;
      return;
    end
    x1 = px;
    y1 = py;
    rdx = round_cells(x1 - trail_x);
    rdy = round_cells(y1 - trail_y);
    if (start || !trail_open || rdx == 0 || rdy == 0) begin
      // first point of a path, or a straight move: passes through as is
      expect_beat(x1, y1, 1'b1, 1'b0);
    end else begin
      ax = (rdx < 0) ? -rdx : rdx;
      ay = (rdy < 0) ? -rdy : rdy;
      steps = (ax > ay) ? ax : ay;
      sat = steps > MAX_SEG_STEPS;
      if (sat) steps = MAX_SEG_STEPS;
      sx = (rdx > 0) ? ONE_I : -ONE_I;
      sy = (rdy > 0) ? ONE_I : -ONE_I;
      cx = trail_x;
      cy = trail_y;
      for (int s = 0; s < steps; s++) begin
        hf = !cell_blocked(cx + sx, cy);
        vf = !cell_blocked(cx, cy + sy);
        // exactly one orthogonal neighbor free: step around the corner first
        if (hf != vf) expect_beat(hf ? cx + sx : cx, hf ? cy : cy + sy, 1'b0, sat);
        cx += sx;
        cy += sy;
        expect_beat(cx, cy, s == steps - 1, sat);
      end
    end
    // the presented point is the reference even when the walk stopped short
    trail_x = x1;
    trail_y = y1;
    trail_open = 1'b1;
  endtask

  task automatic report_mismatch(input string what);
    if (mismatch_count < 40) $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // driver, receiver and monitor
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : drive_items
    path_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_items.pop_front();
        in_valid <= 1'b1;
        opcode <= nxt.op;
        cell_index <= nxt.idx;
        cell_cost <= nxt.cost;
        point_x <= nxt.px;
        point_y <= nxt.py;
        path_start <= nxt.start;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin : watch_ports
    detour_beat_t want;
    if (!rst) begin
      if (in_valid && !in_stall)
        detour_item(opcode, cell_index, cell_cost, point_x, point_y, path_start);
      if (out_valid && !out_stall) begin
        if (detour_beats.size() == 0) begin
          report_mismatch($sformatf("beat (%0d,%0d) with nothing expected", out_x, out_y));
        end else begin
          want = detour_beats.pop_front();
          if (out_x !== want.x)
            report_mismatch($sformatf("out_x got %0d want %0d", out_x, want.x));
          if (out_y !== want.y)
            report_mismatch($sformatf("out_y got %0d want %0d", out_y, want.y));
          if (last_of_run !== want.last)
            report_mismatch($sformatf("last_of_run got %b want %b", last_of_run, want.last));
          if (steps_saturated !== want.sat)
            report_mismatch($sformatf("steps_saturated got %b want %b",
                                      steps_saturated, want.sat));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus generation
  // ---------------------------------------------------------------------------

  // true when a walk would look at an in-map cell that never got a cost
  function automatic bit walk_touches_unwritten(input int x0, input int y0,
                                                input int x1, input int y1);
    int rdx, rdy, ax, ay, steps, xe, ye, ca, cb, ra, rb, lo_x, hi_x, lo_y, hi_y, w, h;
    int addr;
    rdx = round_cells(x1 - x0);
    rdy = round_cells(y1 - y0);
    if (rdx == 0 || rdy == 0) return 1'b0;
    ax = (rdx < 0) ? -rdx : rdx;
    ay = (rdy < 0) ? -rdy : rdy;
    steps = (ax > ay) ? ax : ay;
    if (steps > MAX_SEG_STEPS) steps = MAX_SEG_STEPS;
    xe = x0 + ((rdx > 0) ? steps : -steps) * ONE_I;
    ye = y0 + ((rdy > 0) ? steps : -steps) * ONE_I;
    ca = x0 / ONE_I;
    cb = xe / ONE_I;
    ra = y0 / ONE_I;
    rb = ye / ONE_I;
    lo_x = (ca < cb) ? ca : cb;
    hi_x = (ca < cb) ? cb : ca;
    lo_y = (ra < rb) ? ra : rb;
    hi_y = (ra < rb) ? rb : ra;
    w = model_cfg.map_width;
    h = model_cfg.map_height;
    // truncation is monotonic, so the corner box covers every probed cell
    for (int ix = lo_x; ix <= hi_x; ix++) begin
      for (int iy = lo_y; iy <= hi_y; iy++) begin
        if (ix >= 0 && iy >= 0 && ix < w && iy < h) begin
          addr = iy * w + ix;
          if (addr < MAP_CELLS && !cost_written[addr]) return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic int pick_cost();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return $urandom_range(0, 255);
    if (roll < 55) return model_cfg.unknown_level;
    return $urandom_range(250, 255);
  endfunction

  task automatic queue_write(input int idx, input int cost);
    path_item_t it;
    it.op = OP_MAP_WRITE;
    it.idx = IDX_W'(idx);
    it.cost = COST_W'(cost);
    it.px = PT_W'($urandom);
    it.py = PT_W'($urandom);
    it.start = $urandom_range(0, 1);
    cost_written[idx] = 1'b1;
    pending_items = {pending_items, it};
  endtask

  task automatic queue_point(input int x, input int y, input bit start);
    path_item_t it;
    it.op = OP_POINT;
    it.idx = IDX_W'($urandom);
    it.cost = COST_W'($urandom);
    it.px = PT_W'(x);
    it.py = PT_W'(y);
    it.start = start;
    gen_x = x;
    gen_y = y;
    gen_started = 1'b1;
    pending_items = {pending_items, it};
  endtask

  // next path point: mostly short diagonal hops from the last point, some long
  // saturating walks, straight moves and far jumps; a fresh path now and then or if nothing is safe
  task automatic plan_point();
    int x, y, dx, dy, roll, tries;
    bit placed;
    placed = 1'b0;
    if (gen_started && $urandom_range(0, 99) >= 8) begin
      for (tries = 0; tries < 30 && !placed; tries++) begin
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          dx = int'($urandom_range(0, 256)) - 128;
          dy = int'($urandom_range(0, 256)) - 128;
        end else if (roll < 72) begin
          dx = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(320, 800));
          dy = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(16, 800));
        end else if (roll < 84) begin
          // one axis rounds to zero
          dx = int'($urandom_range(0, 14)) - 7;
          dy = int'($urandom_range(0, 400)) - 200;
          if ($urandom_range(0, 1)) begin
            dx = dy;
            dy = int'($urandom_range(0, 14)) - 7;
          end
        end else begin
          dx = int'($urandom_range(0, 8191)) - 4096 - gen_x;
          dy = int'($urandom_range(0, 8191)) - 4096 - gen_y;
        end
        x = gen_x + dx;
        y = gen_y + dy;
        if (x >= -4096 && x <= 4095 && y >= -4096 && y <= 4095 &&
            !walk_touches_unwritten(gen_x, gen_y, x, y)) begin
          queue_point(x, y, 1'b0);
          placed = 1'b1;
        end
      end
    end
    if (!placed) begin
      x = (zone_x0 - 2 + int'($urandom_range(0, zone_w + 3))) * ONE_I +
          int'($urandom_range(0, ONE_I - 1));
      y = (zone_y0 - 2 + int'($urandom_range(0, zone_h + 3))) * ONE_I +
          int'($urandom_range(0, ONE_I - 1));
      queue_point(x, y, 1'b1);
    end
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 20) begin
        if ($urandom_range(0, 99) < 70) queue_write($urandom_range(0, 1023), pick_cost());
        else queue_write($urandom_range(0, MAP_CELLS - 1), pick_cost());
      end else begin
        plan_point();
      end
    end
  endtask

  task automatic set_zone(input int x0, input int y0, input int w, input int h);
    zone_x0 = x0;
    zone_y0 = y0;
    zone_w = w;
    zone_h = h;
  endtask

  // every register, one per cycle, only while the block is idle
  task automatic set_config(input int w, input int h, input int uok, input int unk,
                            input int insc);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_MAP_WIDTH;
    cfg_data <= CFG_DATA_W'(w);
    model_cfg.map_width = DIM_W'(w);
    @(posedge clk);
    cfg_index <= CFG_MAP_HEIGHT;
    cfg_data <= CFG_DATA_W'(h);
    model_cfg.map_height = DIM_W'(h);
    @(posedge clk);
    cfg_index <= CFG_UNKNOWN_OK;
    cfg_data <= CFG_DATA_W'(uok);
    model_cfg.unknown_ok = uok[0];
    @(posedge clk);
    cfg_index <= CFG_UNKNOWN_LEVEL;
    cfg_data <= CFG_DATA_W'(unk);
    model_cfg.unknown_level = COST_W'(unk);
    @(posedge clk);
    cfg_index <= CFG_INSCRIBED_LEVEL;
    cfg_data <= CFG_DATA_W'(insc);
    model_cfg.inscribed_level = COST_W'(insc);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // sender holds off until every expected beat is back, then lets a trailing
  // map write settle
  task automatic drain_results();
    while (pending_items.size() != 0 || in_valid || detour_beats.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // sender idles 28 in 100, receiver 45 in 100
    send_idle_pct = 28;
    recv_idle_pct = 45;
    // known costs for the lowest cells; random walks stay on written cells
    for (int i = 0; i < 64; i++) queue_write(i, pick_cost());
    drain_results();

    // 16x16 map, lowest four rows known: directed part
    set_config(16, 16, 0, 255, 253);
    set_zone(0, 0, 16, 4);
    queue_write(MAP_CELLS - 1, 255);
    queue_write(1, 255);                  // (1,0) unknown -> blocked
    queue_write(16, 0);                   // (0,1) free
    queue_write(18, 0);                   // (2,1) free
    queue_write(33, 253);                 // (1,2) exactly inscribed -> blocked
    queue_write(17, 252);                 // (1,1) just below inscribed
    queue_write(34, 0);
    queue_point(0, 0, 1'b0);              // no previous point yet: passes through
    queue_point(16, 16, 1'b0);            // detour through the vertical neighbor
    queue_point(32, 32, 1'b0);            // detour through the horizontal neighbor
    queue_point(39, 40, 1'b0);            // x rounds to zero: straight through
    queue_point(47, 32, 1'b0);            // exact halves round away from zero
    queue_point(-8, 8, 1'b0);             // negative walk, a fraction below zero stays in cell 0
    queue_point(-4096, -4096, 1'b1);      // extremes
    queue_point(4095, 4095, 1'b0);        // clamped walk
    queue_point(-4096, -4096, 1'b0);
    queue_point(160, 48, 1'b1);
    queue_point(-200, -12, 1'b0);         // long walk running off the map
    queue_point(4095, -4096, 1'b1);
    queue_point(-4096, 4095, 1'b0);
    queue_random(8);
    drain_results();

    // 256 by 256 map, only the lowest cells known
    set_config(256, 256, 1, 0, 128);
    set_zone(0, 0, 40, 1);
    queue_random(6);
    drain_results();

    // idling the other way round
    send_idle_pct = 45;
    recv_idle_pct = 28;
    set_config(1, 256, 0, 254, 255);
    set_zone(0, 0, 1, 30);
    queue_random(6);
    drain_results();

    set_config(256, 1, 1, 255, 0);
    set_zone(0, 0, 30, 1);
    queue_random(6);
    drain_results();

    // map larger than the store: high rows lie beyond the last address
    set_config(511, 511, 0, 255, 253);
    set_zone(0, 135, 30, 30);
    queue_random(5);
    drain_results();

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(0, 5, 0, 255, 253);        // zero width: everything blocked
    set_zone(0, 0, 8, 8);
    queue_random(5);
    drain_results();

    set_config(40, 25, 0, 255, 253);
    set_zone(0, 0, 24, 2);
    queue_random(5);
    drain_results();
    queue_random(5);
    drain_results();

    repeat (24) @(posedge clk);
    if (mismatch_count == 0 && detour_beats.size() == 0) begin
      $display("tb_corner_hugging_diagonal_detour: clean");
    end else begin
      $display("tb_corner_hugging_diagonal_detour: errors");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/chdd_pkg.sv
design/chdd_map_ram.sv
design/chdd_cell_probe.sv
design/chdd_walk.sv
design/corner_hugging_diagonal_detour.sv
sim/tb_corner_hugging_diagonal_detour.sv
